// ===== rtl/iord_pkg.sv =====
// ---------------------------------------------------------------------------
// iord_pkg
// shared types, constants and helpers of the i/o region map decoder
// ---------------------------------------------------------------------------
package iord_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ADDR_W = 32;
  localparam int TAG_W  = 8;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    MODE_MOUNT   = 3'd0,
    MODE_UNMOUNT = 3'd1,
    MODE_REMAP   = 3'd2,
    MODE_READ    = 3'd3,
    MODE_WRITE   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ABSENT  = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_OVERLAP = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_FINISH
  } fsm_e;

  // one window as held in the slot memory
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    logic              rd;
    logic              wr;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // compare stage control, one slot per cycle
  typedef struct packed {
    logic              clear;
    logic              vld;
    logic [SLOT_W-1:0] idx;
  } scan_ctrl_t;

  // accumulated outcome of one scan
  typedef struct packed {
    logic              tag_hit;
    logic [SLOT_W-1:0] tag_slot;
    logic [SLOTS-1:0]  ovl_vec;
    logic              acc_hit;
    logic [SLOT_W-1:0] acc_slot;
    logic [ADDR_W-1:0] acc_off;
  } scan_res_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } pick_t;

  // lowest set bit
  function automatic pick_t first_set(input logic [SLOTS-1:0] v);
    pick_t p;
    p.found = 1'b0;
    p.idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p.found = 1'b1;
        p.idx   = SLOT_W'(i);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/iord_ram.sv =====
// ---------------------------------------------------------------------------
// iord_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module iord_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/iord_scan.sv =====
// ---------------------------------------------------------------------------
// iord_scan
// per-slot compare stage: tag search, overlap vector and access match
// ---------------------------------------------------------------------------
module iord_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  iord_pkg::scan_ctrl_t      ctrl_i,
  input  logic [iord_pkg::SLOTS-1:0] used_i,
  input  iord_pkg::slot_entry_t     entry_i,
  input  iord_pkg::mode_e           mode_i,
  input  logic [iord_pkg::TAG_W-1:0]  tag_i,
  input  logic [iord_pkg::ADDR_W-1:0] first_i,
  input  logic [iord_pkg::ADDR_W-1:0] last_i,
  input  logic [iord_pkg::ADDR_W-1:0] addr_i,
  output iord_pkg::scan_res_t       res_o
);
  import iord_pkg::*;

  scan_res_t res_q, res_d;
  logic      live;
  logic      cap;
  logic      in_win;

  always_comb begin
    live   = ctrl_i.vld && used_i[ctrl_i.idx];
    cap    = (mode_i == MODE_READ) ? entry_i.rd :
             (mode_i == MODE_WRITE) ? entry_i.wr : 1'b0;
    in_win = (entry_i.first <= addr_i) && (addr_i <= entry_i.last);
    res_d  = res_q;
    if (ctrl_i.clear) begin
      res_d = '0;
    end else if (live) begin
      // lowest slot holding the tag wins
      if (!res_q.tag_hit && entry_i.tag == tag_i) begin
        res_d.tag_hit  = 1'b1;
        res_d.tag_slot = ctrl_i.idx;
      end
      if (first_i <= entry_i.last && entry_i.first <= last_i) begin
        res_d.ovl_vec[ctrl_i.idx] = 1'b1;
      end
      // later (higher) matches overwrite earlier ones
      if (cap && in_win) begin
        res_d.acc_hit  = 1'b1;
        res_d.acc_slot = ctrl_i.idx;
        res_d.acc_off  = addr_i - entry_i.first;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  a_tag_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.tag_hit && !ctrl_i.clear |=> res_q.tag_slot == $past(res_q.tag_slot))
    else $error("tag search slot changed after first match");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> !res_q.tag_hit && !res_q.acc_hit && res_q.ovl_vec == '0)
    else $error("scan result not cleared");

  a_ovl_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.vld && !used_i[ctrl_i.idx] && !ctrl_i.clear |=>
      res_q.ovl_vec == $past(res_q.ovl_vec))
    else $error("free slot flagged as overlapping");

endmodule

// ===== rtl/io_region_map_decoder.sv =====
// ---------------------------------------------------------------------------
// io_region_map_decoder
// device window table with mount, unmount, remap and access decode
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request walks
// the slot memory once, one slot per cycle through its single read port, and
// busy stays high through the slot reads, the last compare (drain state) and
// the table update (finish state). The single result is shown on the output
// ports for exactly one cycle with valid_o high; it cannot be held off, so it
// must be captured then. A new request is taken in the same cycle that the
// previous result is shown, so a new request is taken only after the previous
// one has finished.
// Slot occupancy lives in flip-flops cleared by reset; window contents sit
// in a memory that needs no clearing pass.
module io_region_map_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  mode_i,
  input  logic [iord_pkg::TAG_W-1:0]  device_tag_i,
  input  logic [iord_pkg::ADDR_W-1:0] window_start_i,
  input  logic [iord_pkg::ADDR_W-1:0] window_end_i,
  input  logic                        can_read_i,
  input  logic                        can_write_i,
  input  logic [iord_pkg::ADDR_W-1:0] access_address_i,
  input  logic [iord_pkg::DATA_W-1:0] write_value_i,
  output logic                        valid_o,
  output logic [1:0]                  status_o,
  output logic                        hit_o,
  output logic [iord_pkg::SLOT_W-1:0] slot_o,
  output logic [iord_pkg::ADDR_W-1:0] offset_o,
  output logic [iord_pkg::DATA_W-1:0] routed_value_o
);
  import iord_pkg::*;

  fsm_e              state_q, state_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [SLOT_W-1:0] cmp_idx_q;
  logic [SLOTS-1:0]  used_q, used_d;

  // request payload
  mode_e             mode_q;
  logic [TAG_W-1:0]  tag_q;
  logic [ADDR_W-1:0] first_q, last_q, addr_q;
  logic              rd_q, wr_q;
  logic [DATA_W-1:0] wval_q;

  // result registers
  logic              valid_q, valid_d;
  status_e           status_q, status_d;
  logic              hit_q, hit_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [ADDR_W-1:0] off_q, off_d;
  logic [DATA_W-1:0] routed_q, routed_d;

  logic              accept;
  logic              ram_re, ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_entry_t       wentry, rentry;
  scan_ctrl_t        sctrl;
  scan_res_t         sres;
  logic [SLOTS-1:0]  tag_oh, used_rm, excl;
  pick_t             free_pick;
  logic              ovl;

  assign busy   = (state_q != FSM_IDLE);
  assign accept = start && !busy;

  assign sctrl.clear = accept;
  assign sctrl.vld   = cmp_vld_q;
  assign sctrl.idx   = cmp_idx_q;

  assign wentry.tag   = tag_q;
  assign wentry.first = first_q;
  assign wentry.last  = last_q;
  assign wentry.rd    = rd_q;
  assign wentry.wr    = wr_q;

  iord_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wentry),
    .re_i    (ram_re),
    .raddr_i (cnt_q),
    .rdata_o (rentry)
  );

  iord_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sctrl),
    .used_i  (used_q),
    .entry_i (rentry),
    .mode_i  (mode_q),
    .tag_i   (tag_q),
    .first_i (first_q),
    .last_i  (last_q),
    .addr_i  (addr_q),
    .res_o   (sres)
  );

  // remap frees the tagged slot before looking for room
  always_comb begin
    tag_oh    = SLOTS'(1) << sres.tag_slot;
    used_rm   = used_q & ~tag_oh;
    excl      = (mode_q == MODE_REMAP) ? tag_oh : '0;
    free_pick = first_set(~((mode_q == MODE_REMAP) ? used_rm : used_q));
    ovl       = |(sres.ovl_vec & ~excl);
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmp_vld_d = 1'b0;
    used_d    = used_q;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = free_pick.idx;
    valid_d   = 1'b0;
    status_d  = STAT_ABSENT;
    hit_d     = 1'b0;
    slot_d    = '0;
    off_d     = '0;
    routed_d  = '0;
    case (state_q)
      FSM_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        ram_re    = 1'b1;
        cmp_vld_d = 1'b1;
        if (cnt_q == SLOT_W'(SLOTS - 1)) begin
          state_d = FSM_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      FSM_DRAIN: begin
        state_d = FSM_FINISH;
      end
      FSM_FINISH: begin
        state_d = FSM_IDLE;
        valid_d = 1'b1;
        case (mode_q)
          MODE_MOUNT: begin
            if (!free_pick.found) begin
              status_d = STAT_FULL;
            end else if (ovl) begin
              status_d = STAT_OVERLAP;
            end else begin
              status_d = STAT_OK;
              slot_d   = free_pick.idx;
              ram_we   = 1'b1;
              used_d   = used_q | (SLOTS'(1) << free_pick.idx);
            end
          end
          MODE_UNMOUNT: begin
            if (sres.tag_hit) begin
              status_d = STAT_OK;
              slot_d   = sres.tag_slot;
              used_d   = used_rm;
            end
          end
          MODE_REMAP: begin
            if (sres.tag_hit) begin
              if (ovl) begin
                status_d = STAT_OVERLAP;
                used_d   = used_rm;
              end else begin
                status_d = STAT_OK;
                slot_d   = free_pick.idx;
                ram_we   = 1'b1;
                used_d   = used_rm | (SLOTS'(1) << free_pick.idx);
              end
            end
          end
          MODE_READ, MODE_WRITE: begin
            if (sres.acc_hit) begin
              status_d = STAT_OK;
              hit_d    = 1'b1;
              slot_d   = sres.acc_slot;
              off_d    = sres.acc_off;
              routed_d = (mode_q == MODE_WRITE) ? wval_q : '0;
            end
          end
          default: begin
            status_d = STAT_ABSENT;
          end
        endcase
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      used_q    <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cnt_q;
      used_q    <= used_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_e'(mode_i);
      tag_q   <= device_tag_i;
      first_q <= window_start_i;
      last_q  <= window_end_i;
      rd_q    <= can_read_i;
      wr_q    <= can_write_i;
      addr_q  <= access_address_i;
      wval_q  <= write_value_i;
    end
    status_q <= status_d;
    hit_q    <= hit_d;
    slot_q   <= slot_d;
    off_q    <= off_d;
    routed_q <= routed_d;
  end

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign hit_o          = hit_q;
  assign slot_o         = slot_q;
  assign offset_o       = off_q;
  assign routed_value_o = routed_q;

  a_valid_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q) == FSM_FINISH)
    else $error("result strobe without a finished request");

  a_write_in_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == FSM_FINISH && !ram_re)
    else $error("slot memory written outside the update cycle");

  a_mount_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == STAT_OK && mode_q == MODE_MOUNT |->
      $countones(used_q) == $countones($past(used_q)) + 1)
    else $error("successful mount did not take exactly one slot");

  a_used_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != FSM_FINISH |=> $stable(used_q))
    else $error("slot occupancy changed outside the update cycle");

endmodule
